// ===== sv/tlptm_pkg.sv =====
// ----------------------------------------------------------------------------
// tlptm_pkg
// Shared types and constants of the two-level page table manager: item
// structs, operation and error codes, page entry layout, control structs.
// ----------------------------------------------------------------------------
package tlptm_pkg;

    // address and page geometry
    localparam int ADDR_W           = 32;
    localparam int PAGE_OFFSET_BITS = 12;
    localparam int FRAME_W          = ADDR_W - PAGE_OFFSET_BITS;

    // page entry layout: frame, present, writable, user
    localparam int ENTRY_W      = 23;
    localparam int ENT_PRESENT  = 20;
    localparam int ENT_WRITABLE = 21;
    localparam int ENT_USER     = 22;

    // operation codes
    localparam logic [1:0] OP_TRANSLATE = 2'd0;
    localparam logic [1:0] OP_MAP       = 2'd1;
    localparam logic [1:0] OP_UNMAP     = 2'd2;

    // error codes
    localparam logic [1:0] ERR_OK         = 2'd0;
    localparam logic [1:0] ERR_MISALIGNED = 2'd1;
    localparam logic [1:0] ERR_ALREADY    = 2'd2;
    localparam logic [1:0] ERR_NOT_MAPPED = 2'd3;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] virtual_address;
        logic [ADDR_W-1:0] physical_address;
        logic              read_only;
        logic              user_access;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic [1:0]        err_code;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic clear;   // clearing pass write
        logic load;    // capture item and start table reads
        logic commit;  // write back and load the output register
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_done;  // last entry being cleared
        logic out_free;    // output register can take a result
    } t_ctl_sts;

endpackage

// ===== sv/tlptm_ram.sv =====
// ----------------------------------------------------------------------------
// tlptm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlptm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/tlptm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlptm_ctrl
// Controller: clearing pass after reset, then one item at a time through
// read and write-back.
// ----------------------------------------------------------------------------
module tlptm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  tlptm_pkg::t_ctl_sts i_sts,
    output tlptm_pkg::t_ctl_cmd o_cmd,
    output logic                o_in_stall
);
    import tlptm_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

// ===== sv/tlptm_dpath.sv =====
// ----------------------------------------------------------------------------
// tlptm_dpath
// Datapath: item register, directory and entry RAMs, clear counter,
// result logic and output register.
// ----------------------------------------------------------------------------
module tlptm_dpath #(
    parameter int DIR_INDEX_BITS   = 10,
    parameter int TABLE_INDEX_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tlptm_pkg::t_ctl_cmd  i_cmd,
    output tlptm_pkg::t_ctl_sts  o_sts,
    input  tlptm_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tlptm_pkg::t_out_item o_out_item
);
    import tlptm_pkg::*;

    localparam int SLOT_BITS = DIR_INDEX_BITS + TABLE_INDEX_BITS;
    localparam int DIR_DEPTH = 1 << DIR_INDEX_BITS;
    localparam int ENT_DEPTH = 1 << SLOT_BITS;

    t_in_item            r_item;
    logic [SLOT_BITS-1:0] r_clr_addr;
    logic                r_out_valid;
    t_out_item           r_out_item;

    logic [DIR_INDEX_BITS-1:0] dir_raddr;
    logic [SLOT_BITS-1:0]      ent_raddr;
    logic [DIR_INDEX_BITS-1:0] dir_waddr;
    logic [SLOT_BITS-1:0]      ent_waddr;
    logic                      dir_we;
    logic                      dir_wdata;
    logic                      ent_we;
    logic [ENTRY_W-1:0]        ent_wdata;
    logic                      dir_rd;
    logic [ENTRY_W-1:0]        ent_rd;
    logic                      va_aligned;
    logic                      pa_aligned;
    logic                      set_dir;
    logic                      write_ent;
    logic [ENTRY_W-1:0]        new_entry;
    t_out_item                 result;

    // item register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
    end

    // read addresses come from the incoming item at load, else from the held item
    always_comb begin
        if (i_cmd.load) begin
            dir_raddr = i_in_item.virtual_address[PAGE_OFFSET_BITS+TABLE_INDEX_BITS
                                                  +: DIR_INDEX_BITS];
            ent_raddr = i_in_item.virtual_address[PAGE_OFFSET_BITS +: SLOT_BITS];
        end else begin
            dir_raddr = r_item.virtual_address[PAGE_OFFSET_BITS+TABLE_INDEX_BITS
                                               +: DIR_INDEX_BITS];
            ent_raddr = r_item.virtual_address[PAGE_OFFSET_BITS +: SLOT_BITS];
        end
    end

    // clear counter, walks every entry once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_sts.clear_done = i_cmd.clear && (&r_clr_addr);

    // result and write-back decisions
    assign va_aligned = (r_item.virtual_address[PAGE_OFFSET_BITS-1:0] == '0);
    assign pa_aligned = (r_item.physical_address[PAGE_OFFSET_BITS-1:0] == '0);

    always_comb begin
        new_entry = {r_item.user_access, ~r_item.read_only, 1'b1,
                     r_item.physical_address[ADDR_W-1:PAGE_OFFSET_BITS]};
    end

    always_comb begin
        result    = '0;
        set_dir   = 1'b0;
        write_ent = 1'b0;
        case (r_item.operation)
            OP_TRANSLATE: begin
                if (!dir_rd) begin
                    result.result_address = '1;
                    result.err_code       = ERR_NOT_MAPPED;
                end else begin
                    result.result_address = {ent_rd[FRAME_W-1:0],
                                             r_item.virtual_address[PAGE_OFFSET_BITS-1:0]};
                end
            end
            OP_MAP: begin
                if (!va_aligned || !pa_aligned) begin
                    result.err_code = ERR_MISALIGNED;
                end else begin
                    set_dir = 1'b1;
                    if (ent_rd[ENT_PRESENT]) begin
                        result.err_code = ERR_ALREADY;
                    end else begin
                        write_ent = 1'b1;
                    end
                end
            end
            OP_UNMAP: begin
                if (!va_aligned) begin
                    result.err_code = ERR_MISALIGNED;
                end else if (!dir_rd || !ent_rd[ENT_PRESENT]) begin
                    result.err_code = ERR_NOT_MAPPED;
                end else begin
                    write_ent = 1'b1;
                end
            end
            default: begin
                result = '0;
            end
        endcase
    end

    // write ports: clearing pass or commit
    always_comb begin
        if (i_cmd.clear) begin
            dir_we    = 1'b1;
            dir_waddr = r_clr_addr[DIR_INDEX_BITS-1:0];
            dir_wdata = 1'b0;
            ent_we    = 1'b1;
            ent_waddr = r_clr_addr;
            ent_wdata = '0;
        end else begin
            dir_we    = i_cmd.commit && set_dir;
            dir_waddr = dir_raddr;
            dir_wdata = 1'b1;
            ent_we    = i_cmd.commit && write_ent;
            ent_waddr = ent_raddr;
            ent_wdata = (r_item.operation == OP_MAP) ? new_entry : '0;
        end
    end

    tlptm_ram #(
        .WIDTH (1),
        .DEPTH (DIR_DEPTH)
    ) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_waddr (dir_waddr),
        .i_wdata (dir_wdata),
        .i_raddr (dir_raddr),
        .o_rdata (dir_rd)
    );

    tlptm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENT_DEPTH)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rd)
    );

    // output register
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== sv/two_level_page_table_manager.sv =====
// ----------------------------------------------------------------------------
// two_level_page_table_manager
// Two-level page table: directory present bits and page entries in RAM,
// translate, map and unmap items with one result each.
//
//   channel   direction   handshake                  payload
//   in        input       i_in_valid / o_in_stall    i_in_item  (t_in_item)
//   out       output      o_out_valid / i_out_stall  o_out_item (t_out_item)
//
// - for each item the accept edge starts the directory and entry RAM reads,
//   and the commit edge, once the output register is free, writes back
//   and loads the output register; the registered read of the entry RAM
//   precedes its write-back, and one item is in flight at a time
// - after reset a clearing pass over 2^(DIR_INDEX_BITS+TABLE_INDEX_BITS)
//   entries (1048576 at the defaults) zeroes both RAMs, with o_in_stall high
// - a result waits in the output register while i_out_stall is high; the next
//   item is still accepted and waits for write-back until the register frees
// ----------------------------------------------------------------------------
module two_level_page_table_manager #(
    parameter int DIR_INDEX_BITS   = 10,
    parameter int TABLE_INDEX_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  tlptm_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tlptm_pkg::t_out_item o_out_item
);
    import tlptm_pkg::*;

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    // sequencing
    tlptm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // tables and result
    tlptm_dpath #(
        .DIR_INDEX_BITS   (DIR_INDEX_BITS),
        .TABLE_INDEX_BITS (TABLE_INDEX_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== sv/tlptm_checker.sv =====
// ----------------------------------------------------------------------------
// tlptm_checker
// Port-level checks of the page table manager, bound to the top level.
// ----------------------------------------------------------------------------
module tlptm_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input tlptm_pkg::t_in_item  i_in_item,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input tlptm_pkg::t_out_item o_out_item
);
    import tlptm_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // one item in flight: stall right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while an item is in flight");

    // clearing pass follows reset: no result, no accept
    a_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid && o_in_stall)
        else $error("block active right after reset");

    // a new result only while an item was in flight
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without an item");

    // error results carry zero, or all ones for a failed translate
    a_err_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.err_code != ERR_OK) |->
            (o_out_item.result_address == '0) ||
            ((o_out_item.result_address == '1) &&
             (o_out_item.err_code == ERR_NOT_MAPPED)))
        else $error("bad address on an error result");

endmodule

bind two_level_page_table_manager tlptm_checker u_tlptm_checker (.*);
